// ===== sv/weighted_failover_priority_list_core_defines.svh =====
// Assertion macros shared by the weighted failover priority list RTL.
`ifndef WEIGHTED_FAILOVER_PRIORITY_LIST_CORE_DEFINES_SVH
`define WEIGHTED_FAILOVER_PRIORITY_LIST_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Property that must hold at every clock edge out of reset.
`define WFPL_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Antecedent in one cycle implies consequent in the next.
`define WFPL_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);
`else
`define WFPL_ASSERT(name, prop, msg)
`define WFPL_ASSERT_NEXT(name, ante, cons, msg)
`endif

`endif

// ===== sv/wfpl_pkg.sv =====
// Types and codes shared by the weighted failover priority list modules.
package wfpl_pkg;

  localparam int unsigned OpW         = 3;
  localparam int unsigned IdPortW     = 8;
  localparam int unsigned WeightPortW = 16;

  typedef enum logic [OpW-1:0] {
    OP_INSERT         = 3'd0,
    OP_FIRST_AVAIL    = 3'd1,
    OP_FIRST_UNAVAIL  = 3'd2,
    OP_MARK_UNAVAIL   = 3'd3,
    OP_MARK_AVAIL     = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_ABSENT = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_EVAL,
    S_DONE
  } fsm_e;

  // Request payload as it arrives on the ports.
  typedef struct packed {
    logic [OpW-1:0]         op;
    logic [IdPortW-1:0]     node_id;
    logic [WeightPortW-1:0] weight;
    logic                   start_available;
  } req_t;

  typedef struct packed {
    logic               found;
    logic [IdPortW-1:0] result_id;
    status_e            status;
  } res_t;

  // Top level to sequencer.
  typedef struct packed {
    logic start;
    logic ack;
  } ctl_t;

  // Sequencer to top level.
  typedef struct packed {
    logic idle;
    logic done;
    res_t res;
  } stat_t;

endpackage

// ===== sv/wfpl_ram.sv =====
// Entry memory: one write port, one read port with registered read data.
module wfpl_ram #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 25
) (
  input  logic                       clk_i,
  input  logic                       rd_en_i,
  input  logic [$clog2(DEPTH)-1:0]   rd_addr_i,
  output logic [WIDTH-1:0]           rd_data_o,
  input  logic                       we_i,
  input  logic [$clog2(DEPTH)-1:0]   wr_addr_i,
  input  logic [WIDTH-1:0]           wr_data_i
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== sv/wfpl_seq.sv =====
// Sequencer with the shared entry compare unit: scans, shifts and marks entries.
`include "weighted_failover_priority_list_core_defines.svh"
module wfpl_seq
  import wfpl_pkg::*;
#(
  parameter int unsigned DEPTH       = 16,
  parameter int unsigned ID_BITS     = 8,
  parameter int unsigned WEIGHT_BITS = 16
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  ctl_t                                    ctl_i,
  input  req_t                                    req_i,
  output stat_t                                   stat_o,
  output logic                                    mem_rd_en_o,
  output logic [$clog2(DEPTH)-1:0]                mem_rd_addr_o,
  input  logic [ID_BITS+WEIGHT_BITS:0]            mem_rd_data_i,
  output logic                                    mem_we_o,
  output logic [$clog2(DEPTH)-1:0]                mem_wr_addr_o,
  output logic [ID_BITS+WEIGHT_BITS:0]            mem_wr_data_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned EW = ID_BITS + WEIGHT_BITS + 1;
  localparam logic [CW-1:0] DepthC = CW'(DEPTH);

  fsm_e                   state_q, state_d;
  logic [OpW-1:0]         op_q;
  logic [ID_BITS-1:0]     id_q;
  logic [WEIGHT_BITS-1:0] w_q;
  logic                   av_q;
  logic [CW-1:0]          idx_q, idx_d;
  logic [CW-1:0]          count_q, count_d;
  res_t                   res_q, res_d;

  // Request fields taken to storage widths.
  logic [ID_BITS+IdPortW-1:0]         id_ext;
  logic [WEIGHT_BITS+WeightPortW-1:0] w_ext;
  logic [ID_BITS-1:0]                 id_in;
  logic [WEIGHT_BITS-1:0]             w_in;
  logic                               av_in;

  // Entry read back from memory.
  logic [ID_BITS-1:0]         rd_id;
  logic [WEIGHT_BITS-1:0]     rd_w;
  logic                       rd_av;
  logic [ID_BITS+IdPortW-1:0] rd_id_ext;

  logic          start, req_ins, req_known, full;
  logic          is_ins, is_mark, scan_end, hit;
  logic [CW-1:0] idx_m1;

  assign start     = ctl_i.start && (state_q == S_IDLE);
  assign req_ins   = (req_i.op == OP_INSERT);
  assign req_known = (req_i.op <= OP_MARK_AVAIL);
  assign full      = (count_q == DepthC);

  assign id_ext = {{ID_BITS{1'b0}}, req_i.node_id};
  assign w_ext  = {{WEIGHT_BITS{1'b0}}, req_i.weight};
  assign id_in  = id_ext[ID_BITS-1:0];
  assign w_in   = w_ext[WEIGHT_BITS-1:0];

  // Lookups carry the wanted mark in av_q, marks carry the new mark.
  always_comb begin
    case (req_i.op)
      OP_INSERT:        av_in = req_i.start_available;
      OP_FIRST_AVAIL:   av_in = 1'b1;
      OP_MARK_AVAIL:    av_in = 1'b1;
      default:          av_in = 1'b0;
    endcase
  end

  assign rd_id     = mem_rd_data_i[EW-1 -: ID_BITS];
  assign rd_w      = mem_rd_data_i[WEIGHT_BITS:1];
  assign rd_av     = mem_rd_data_i[0];
  assign rd_id_ext = {{IdPortW{1'b0}}, rd_id};

  assign is_ins  = (op_q == OP_INSERT);
  assign is_mark = (op_q == OP_MARK_UNAVAIL) || (op_q == OP_MARK_AVAIL);
  assign idx_m1  = idx_q - CW'(1);

  // Insert walks down from the tail, the others walk up from the head.
  assign scan_end = is_ins ? (idx_q == '0) : (idx_q == count_q);

  // Shared compare unit.
  always_comb begin
    case (op_q)
      OP_INSERT:        hit = (w_q < rd_w);
      OP_FIRST_AVAIL:   hit = (rd_av == av_q);
      OP_FIRST_UNAVAIL: hit = (rd_av == av_q);
      OP_MARK_UNAVAIL:  hit = (rd_id == id_q);
      OP_MARK_AVAIL:    hit = (rd_id == id_q);
      default:          hit = 1'b0;
    endcase
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          if ((req_ins && full) || !req_known) begin
            state_d = S_DONE;
          end else begin
            state_d = S_READ;
          end
        end
      end
      S_READ: begin
        state_d = scan_end ? S_DONE : S_EVAL;
      end
      S_EVAL: begin
        if (is_ins) begin
          state_d = hit ? S_READ : S_DONE;
        end else begin
          state_d = hit ? S_DONE : S_READ;
        end
      end
      S_DONE: begin
        if (ctl_i.ack) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath and memory control.
  always_comb begin
    idx_d         = idx_q;
    count_d       = count_q;
    res_d         = res_q;
    mem_rd_en_o   = 1'b0;
    mem_rd_addr_o = is_ins ? idx_m1[AW-1:0] : idx_q[AW-1:0];
    mem_we_o      = 1'b0;
    mem_wr_addr_o = idx_q[AW-1:0];
    mem_wr_data_o = {id_q, w_q, av_q};
    case (state_q)
      S_IDLE: begin
        if (start) begin
          res_d.found     = 1'b0;
          res_d.result_id = '0;
          res_d.status    = (req_ins && full) ? ST_FULL : ST_OK;
          idx_d           = req_ins ? count_q : '0;
        end
      end
      S_READ: begin
        if (scan_end) begin
          if (is_ins) begin
            mem_we_o = 1'b1;
            count_d  = count_q + CW'(1);
          end else if (is_mark) begin
            res_d.status = ST_ABSENT;
          end
        end else begin
          mem_rd_en_o = 1'b1;
        end
      end
      S_EVAL: begin
        if (is_ins) begin
          mem_we_o = 1'b1;
          if (hit) begin
            // heavier entry moves up one slot
            mem_wr_data_o = mem_rd_data_i;
            idx_d         = idx_m1;
          end else begin
            count_d = count_q + CW'(1);
          end
        end else if (hit) begin
          if (is_mark) begin
            mem_we_o      = 1'b1;
            mem_wr_data_o = {rd_id, rd_w, av_q};
          end else begin
            res_d.found     = 1'b1;
            res_d.result_id = rd_id_ext[IdPortW-1:0];
          end
        end else begin
          idx_d = idx_q + CW'(1);
        end
      end
      S_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (start) begin
      op_q <= req_i.op;
      id_q <= id_in;
      w_q  <= w_in;
      av_q <= av_in;
    end
  end

  assign stat_o.idle = (state_q == S_IDLE);
  assign stat_o.done = (state_q == S_DONE);
  assign stat_o.res  = res_q;

  `WFPL_ASSERT(a_cnt_bound, count_q <= DepthC, "entry count above depth")
  `WFPL_ASSERT(a_we_state, mem_we_o |-> (state_q == S_READ || state_q == S_EVAL), "write outside scan")
  `WFPL_ASSERT_NEXT(a_cnt_idle, state_q == S_IDLE, $stable(count_q), "count changed while idle")

endmodule

// ===== sv/weighted_failover_priority_list_core.sv =====
// Top level of the weighted failover priority list: handshakes, result register, units.
//
// Keeps up to DEPTH entries (id, weight, available mark) sorted by ascending
// weight; equal weights stay in insertion order. Ops: insert (status FULL when
// the table holds DEPTH entries), first available / first unavailable lookup
// (found=0, id=0 when none or the table is empty), mark unavailable / mark
// available on the first entry with a matching id (status ABSENT when none).
// Unused op codes give an OK result and change nothing. Exactly one result
// comes out per accepted item. One item is worked on at a time: in_ready_o is
// high only while the sequencer is idle. The entries sit in a single-port-read
// memory with a registered read, so each entry visited is first read and then
// compared in the shared unit. A scan stops on a compare (a lookup or mark that
// matches, an insert that settles behind a lighter or equal entry) or runs past
// the last entry to read (a lookup or mark with no match, an insert that lands
// at the head). A full-table insert or an unused op goes straight to done. The
// finished result sits in an output register, so the next item can be taken
// while the result waits on out_ready_i. The memory needs no clearing after
// reset: only entries below the count are ever read.
module weighted_failover_priority_list_core
  import wfpl_pkg::*;
#(
  parameter int unsigned DEPTH       = 16,
  parameter int unsigned ID_BITS     = 8,
  parameter int unsigned WEIGHT_BITS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [OpW-1:0]         op_i,
  input  logic [IdPortW-1:0]     node_id_i,
  input  logic [WeightPortW-1:0] weight_i,
  input  logic                   start_available_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic                   found_o,
  output logic [IdPortW-1:0]     result_id_o,
  output logic [1:0]             status_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned EW = ID_BITS + WEIGHT_BITS + 1;

  ctl_t  ctl;
  req_t  req;
  stat_t stat;

  logic          mem_rd_en, mem_we;
  logic [AW-1:0] mem_rd_addr, mem_wr_addr;
  logic [EW-1:0] mem_rd_data, mem_wr_data;

  // Output register: holds a result until the consumer takes it.
  logic                out_valid_q, out_valid_d;
  logic                found_q;
  logic [IdPortW-1:0]  result_id_q;
  status_e             status_q;
  logic                load;

  assign req.op              = op_i;
  assign req.node_id         = node_id_i;
  assign req.weight          = weight_i;
  assign req.start_available = start_available_i;

  assign in_ready_o = stat.idle;
  assign load       = stat.done && (!out_valid_q || out_ready_i);
  assign ctl.start  = in_valid_i && in_ready_o;
  assign ctl.ack    = load;

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      found_q     <= stat.res.found;
      result_id_q <= stat.res.result_id;
      status_q    <= stat.res.status;
    end
  end

  assign out_valid_o = out_valid_q;
  assign found_o     = found_q;
  assign result_id_o = result_id_q;
  assign status_o    = status_q;

  wfpl_seq #(
    .DEPTH       (DEPTH),
    .ID_BITS     (ID_BITS),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctl_i         (ctl),
    .req_i         (req),
    .stat_o        (stat),
    .mem_rd_en_o   (mem_rd_en),
    .mem_rd_addr_o (mem_rd_addr),
    .mem_rd_data_i (mem_rd_data),
    .mem_we_o      (mem_we),
    .mem_wr_addr_o (mem_wr_addr),
    .mem_wr_data_o (mem_wr_data)
  );

  wfpl_ram #(
    .DEPTH (DEPTH),
    .WIDTH (EW)
  ) u_ram (
    .clk_i     (clk_i),
    .rd_en_i   (mem_rd_en),
    .rd_addr_i (mem_rd_addr),
    .rd_data_o (mem_rd_data),
    .we_i      (mem_we),
    .wr_addr_i (mem_wr_addr),
    .wr_data_i (mem_wr_data)
  );

endmodule
